// ===== design/elg_pkg.sv =====
// Shared types and constants for the ElGamal encrypt/decrypt block.
`timescale 1ns / 1ps
`default_nettype none
package elg_pkg;
  localparam int W = 32;
  localparam int CW = $clog2(W + 1);
  localparam logic CMD_ENCRYPT = 1'b0;
  localparam logic CMD_DECRYPT = 1'b1;
  localparam logic [1:0] REG_MODULUS = 2'd0;
  localparam logic [1:0] REG_GENERATOR = 2'd1;
  localparam logic [1:0] REG_PRIVATE_KEY = 2'd2;
  localparam logic [1:0] REG_PUBLIC_KEY = 2'd3;

  typedef enum logic [4:0] {
    ST_IDLE, ST_RED_M, ST_RED_G, ST_RED_Y, ST_RED_A, ST_RED_B, ST_RED_X,
    ST_INIT, ST_BIT, ST_MUL1, ST_MUL2, ST_SQ1, ST_SQ2, ST_NEXT,
    ST_FIN, ST_FIN_W, ST_OUT
  } state_t;

  typedef struct packed {
    logic       start;
    logic [W-1:0] a;
    logic [W-1:0] b;
  } mm_req_t;
endpackage
`default_nettype wire

// ===== design/elg_modmul.sv =====
// Bit-serial modular multiplier and reducer: (a*b) mod p, one bit of b per cycle.
`timescale 1ns / 1ps
`default_nettype none
module elg_modmul (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire elg_pkg::mm_req_t     req,
  input  wire logic [elg_pkg::W-1:0] p,
  output logic                      done,
  output logic [elg_pkg::W-1:0]     prod
);
  logic [elg_pkg::W-1:0] acc_r, acc_nxt, a_r, a_nxt, b_r, b_nxt;
  logic [elg_pkg::CW-1:0] cnt_r, cnt_nxt;
  logic busy_r, busy_nxt, done_r, done_nxt;
  logic [elg_pkg::W:0] dbl, sum;

  // Horner from MSB: acc = 2*acc (+ a), each reduced by one compare-subtract.
  always_comb begin
    dbl = {acc_r, 1'b0};
    if (dbl >= {1'b0, p}) dbl = dbl - {1'b0, p};
    sum = dbl + (b_r[elg_pkg::W-1] ? {1'b0, a_r} : '0);
    if (sum >= {1'b0, p}) sum = sum - {1'b0, p};
    acc_nxt = acc_r; a_nxt = a_r; b_nxt = b_r; cnt_nxt = cnt_r;
    busy_nxt = busy_r; done_nxt = 1'b0;
    if (req.start) begin
      acc_nxt = '0; a_nxt = req.a; b_nxt = req.b;
      cnt_nxt = elg_pkg::CW'(elg_pkg::W); busy_nxt = 1'b1;
    end else if (busy_r) begin
      acc_nxt = sum[elg_pkg::W-1:0];
      b_nxt = {b_r[elg_pkg::W-2:0], 1'b0};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == elg_pkg::CW'(1)) begin
        busy_nxt = 1'b0; done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; done_r <= 1'b0; cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt; done_r <= done_nxt; cnt_r <= cnt_nxt;
    end
    acc_r <= acc_nxt; a_r <= a_nxt; b_r <= b_nxt;
  end

  assign done = done_r;
  assign prod = acc_r;
endmodule
`default_nettype wire

// ===== design/elgamal_encrypt_decrypt.sv =====
// Top level of the ElGamal encrypt/decrypt block.
// Usage: the in_ stream carries one command per transfer. Encrypt (cmd 0)
// returns a = g^k mod p and b = y^k * m mod p; decrypt (cmd 1) returns
// b * a^(p-1-x) mod p in result_first and zero in result_second. Every input
// transfer produces exactly one out_ transfer. The cfg_ port writes modulus,
// generator, private key and public key by index; write only while idle.
// All modular products go through one bit-serial modular multiplier;
// operand reductions run through it as 1 * value, and x in p-1-x is first
// reduced mod (p-1). A modulus below two answers zero on both fields. One
// item is computed at a time; the next transfer can be taken in the cycle
// out_tvalid rises. Reset (synchronous, rst_n low) loads p=3, g=2, x=2,
// y=1 and empties the block. A result sits in the output register until
// out_tready takes it; the next item may already be computing meanwhile
// and waits in its final state until the register is free, so nothing is
// lost on stalls.
`timescale 1ns / 1ps
`default_nettype none
module elgamal_encrypt_decrypt (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // tdata: [0] cmd, [32:1] message, [64:33] nonce, [96:65] cipher_first,
  // [128:97] cipher_second, [135:129] zero
  input  wire logic [135:0] in_tdata,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // tdata: [31:0] result_first, [63:32] result_second
  output logic [63:0]       out_tdata,
  input  wire logic         cfg_we,
  input  wire logic [1:0]   cfg_index,
  input  wire logic [31:0]  cfg_wdata
);
  localparam int W = elg_pkg::W;

  logic [W-1:0] p_r, g_r, x_r, y_r;
  elg_pkg::state_t st_r, st_nxt;
  logic cmd_r, cmd_nxt;
  logic [W-1:0] m_r, m_nxt, k_r, k_nxt, cb_r, cb_nxt;
  logic [W-1:0] bg_r, bg_nxt, by_r, by_nxt, rg_r, rg_nxt, ry_r, ry_nxt;
  logic [W-1:0] e_r, e_nxt, xr_r, xr_nxt;
  logic [W-1:0] o0_r, o0_nxt, o1_r, o1_nxt;
  logic oc_r, oc_nxt;
  logic [elg_pkg::CW-1:0] n_r, n_nxt;
  logic ov_r, ov_nxt;
  elg_pkg::mm_req_t req;
  logic mm_done;
  logic [W-1:0] mm_p, mm_q, pm1;

  // Exponent reduction x mod (p-1) also uses the multiplier, with modulus p-1.
  assign pm1 = p_r - 1'b1;
  assign mm_p = (st_r == elg_pkg::ST_RED_X) ? pm1 : p_r;

  elg_modmul u_mm (.clk, .rst_n, .req, .p(mm_p), .done(mm_done), .prod(mm_q));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_r <= 32'd3; g_r <= 32'd2; x_r <= 32'd2; y_r <= 32'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        elg_pkg::REG_MODULUS:     p_r <= cfg_wdata;
        elg_pkg::REG_GENERATOR:   g_r <= cfg_wdata;
        elg_pkg::REG_PRIVATE_KEY: x_r <= cfg_wdata;
        elg_pkg::REG_PUBLIC_KEY:  y_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // The output register parts the two sides: a new item may start while the
  // previous result still waits for out_tready.
  assign in_tready = (st_r == elg_pkg::ST_IDLE);
  assign out_tvalid = ov_r;
  assign out_tdata = {o1_r, o0_r};

  // The multiplier needs its first operand below the modulus, so every
  // reduction passes a = 1 and streams the unreduced value in as b.
  always_comb begin
    st_nxt = st_r; cmd_nxt = cmd_r; m_nxt = m_r; k_nxt = k_r;
    cb_nxt = cb_r; bg_nxt = bg_r; by_nxt = by_r; rg_nxt = rg_r; ry_nxt = ry_r;
    e_nxt = e_r; xr_nxt = xr_r; o0_nxt = o0_r; o1_nxt = o1_r; n_nxt = n_r;
    oc_nxt = oc_r; ov_nxt = ov_r;
    req.start = 1'b0; req.a = '0; req.b = '0;
    if (ov_r && out_tready) ov_nxt = 1'b0;
    unique case (st_r)
      elg_pkg::ST_IDLE: if (in_tvalid && in_tready) begin
        cmd_nxt = in_tdata[0]; m_nxt = in_tdata[32:1]; k_nxt = in_tdata[64:33];
        cb_nxt = in_tdata[128:97];
        if (p_r < 32'd2) begin
          rg_nxt = '0; ry_nxt = '0; st_nxt = elg_pkg::ST_OUT;
        end else if (in_tdata[0] == elg_pkg::CMD_ENCRYPT) begin
          req.start = 1'b1; req.a = 32'd1; req.b = in_tdata[32:1];
          st_nxt = elg_pkg::ST_RED_M;
        end else begin
          req.start = 1'b1; req.a = 32'd1; req.b = in_tdata[96:65];
          st_nxt = elg_pkg::ST_RED_A;
        end
      end
      elg_pkg::ST_RED_M: if (mm_done) begin
        m_nxt = mm_q; req.start = 1'b1; req.a = 32'd1; req.b = g_r;
        st_nxt = elg_pkg::ST_RED_G;
      end
      elg_pkg::ST_RED_G: if (mm_done) begin
        bg_nxt = mm_q; req.start = 1'b1; req.a = 32'd1; req.b = y_r;
        st_nxt = elg_pkg::ST_RED_Y;
      end
      elg_pkg::ST_RED_Y: if (mm_done) begin
        by_nxt = mm_q; e_nxt = k_r; st_nxt = elg_pkg::ST_INIT;
      end
      elg_pkg::ST_RED_A: if (mm_done) begin
        bg_nxt = mm_q; req.start = 1'b1; req.a = 32'd1; req.b = cb_r;
        st_nxt = elg_pkg::ST_RED_B;
      end
      elg_pkg::ST_RED_B: if (mm_done) begin
        m_nxt = mm_q; req.start = 1'b1; req.a = 32'd1; req.b = x_r;
        st_nxt = elg_pkg::ST_RED_X;
      end
      elg_pkg::ST_RED_X: if (mm_done) begin
        // p-1 == 1 gives mm_q 0 (acc never reaches 1); exponent is then 1.
        xr_nxt = (pm1 == 32'd1) ? '0 : mm_q; st_nxt = elg_pkg::ST_INIT;
      end
      elg_pkg::ST_INIT: begin
        if (cmd_r == elg_pkg::CMD_DECRYPT) e_nxt = pm1 - xr_r;
        rg_nxt = 32'd1; ry_nxt = 32'd1;
        n_nxt = elg_pkg::CW'(W); st_nxt = elg_pkg::ST_BIT;
      end
      elg_pkg::ST_BIT: begin
        if (e_r[0]) begin
          req.start = 1'b1; req.a = rg_r; req.b = bg_r; st_nxt = elg_pkg::ST_MUL1;
        end else begin
          req.start = 1'b1; req.a = bg_r; req.b = bg_r; st_nxt = elg_pkg::ST_SQ1;
        end
      end
      elg_pkg::ST_MUL1: if (mm_done) begin
        rg_nxt = mm_q;
        if (cmd_r == elg_pkg::CMD_ENCRYPT) begin
          req.start = 1'b1; req.a = ry_r; req.b = by_r; st_nxt = elg_pkg::ST_MUL2;
        end else begin
          req.start = 1'b1; req.a = bg_r; req.b = bg_r; st_nxt = elg_pkg::ST_SQ1;
        end
      end
      elg_pkg::ST_MUL2: if (mm_done) begin
        ry_nxt = mm_q; req.start = 1'b1; req.a = bg_r; req.b = bg_r;
        st_nxt = elg_pkg::ST_SQ1;
      end
      elg_pkg::ST_SQ1: if (mm_done) begin
        bg_nxt = mm_q;
        if (cmd_r == elg_pkg::CMD_ENCRYPT) begin
          req.start = 1'b1; req.a = by_r; req.b = by_r; st_nxt = elg_pkg::ST_SQ2;
        end else st_nxt = elg_pkg::ST_NEXT;
      end
      elg_pkg::ST_SQ2: if (mm_done) begin
        by_nxt = mm_q; st_nxt = elg_pkg::ST_NEXT;
      end
      elg_pkg::ST_NEXT: begin
        e_nxt = {1'b0, e_r[W-1:1]}; n_nxt = n_r - 1'b1;
        if (n_r == elg_pkg::CW'(1)) begin
          // All exponent bits are done: one last product folds in the message or, on decrypt, b.
          req.start = 1'b1; req.a = ry_r; req.b = m_r;
          if (cmd_r == elg_pkg::CMD_DECRYPT) req.a = rg_r;
          st_nxt = elg_pkg::ST_FIN;
        end else st_nxt = elg_pkg::ST_BIT;
      end
      elg_pkg::ST_FIN: if (mm_done) begin
        // The result pair is staged in rg_r and ry_r until the output is free.
        if (cmd_r == elg_pkg::CMD_ENCRYPT) begin
          ry_nxt = mm_q;
        end else begin
          rg_nxt = mm_q; ry_nxt = '0;
        end
        st_nxt = elg_pkg::ST_FIN_W;
      end
      elg_pkg::ST_FIN_W: st_nxt = elg_pkg::ST_OUT;
      elg_pkg::ST_OUT: if (!ov_r || out_tready) begin
        o0_nxt = rg_r; o1_nxt = ry_r; oc_nxt = cmd_r;
        ov_nxt = 1'b1; st_nxt = elg_pkg::ST_IDLE;
      end
      default: st_nxt = elg_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= elg_pkg::ST_IDLE; ov_r <= 1'b0; n_r <= '0;
    end else begin
      st_r <= st_nxt; ov_r <= ov_nxt; n_r <= n_nxt;
    end
    cmd_r <= cmd_nxt; m_r <= m_nxt; k_r <= k_nxt; cb_r <= cb_nxt;
    bg_r <= bg_nxt; by_r <= by_nxt; rg_r <= rg_nxt; ry_r <= ry_nxt;
    e_r <= e_nxt; xr_r <= xr_nxt; o0_r <= o0_nxt; o1_r <= o1_nxt;
    oc_r <= oc_nxt;
  end

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r != elg_pkg::ST_IDLE) |-> !in_tready) else $error("accept while busy");
  a_dec_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && oc_r == elg_pkg::CMD_DECRYPT) |-> (o1_r == '0))
    else $error("decrypt second half not zero");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && !out_tready) |=> (ov_r && $stable(out_tdata)))
    else $error("output dropped under stall");
endmodule
`default_nettype wire

// ===== bench/tb_elgamal_encrypt_decrypt.sv =====
// Self-checking testbench for the ElGamal encrypt/decrypt block.
`timescale 1ns / 1ps
`default_nettype none
module tb_elgamal_encrypt_decrypt;

  // Overall bound on the run, which holds about 700 items with stalls.
  localparam int CYCLE_LIMIT = 15_000_000;
  localparam int IDLE_PCT = 28;

  typedef struct {
    logic        cmd;
    logic [31:0] message;
    logic [31:0] nonce;
    logic [31:0] cipher_first;
    logic [31:0] cipher_second;
  } elg_item_t;

  typedef struct {
    logic [31:0] first;
    logic [31:0] second;
  } elg_result_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [135:0] in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [63:0]  out_tdata;
  logic         cfg_we = 1'b0;
  logic [1:0]   cfg_index = elg_pkg::REG_MODULUS;
  logic [31:0]  cfg_wdata = '0;

  // Shadow copy of the key registers, as loaded by reset.
  logic [31:0] mod_p = 32'd3;
  logic [31:0] gen_g = 32'd2;
  logic [31:0] key_x = 32'd2;
  logic [31:0] key_y = 32'd1;

  elg_item_t   pending_items[$];
  elg_result_t expected_results[$];
  elg_item_t   cur_item;
  bit          calm = 1'b0;
  int          errors = 0;
  int          cycles = 0;

  always #4 clk = ~clk;

  elgamal_encrypt_decrypt dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  // Exact modular exponentiation; the product of two 32-bit residues fits
  // in 64 bits, so no double-and-add is needed here.
  function automatic logic [31:0] mod_exp(logic [31:0] base, logic [31:0] ex,
                                          logic [31:0] p);
    longint unsigned r, b, m;
    m = p;
    r = 1 % m;
    b = base % m;
    for (int i = 0; i < 32; i++) begin
      if (ex[i]) r = (r * b) % m;
      b = (b * b) % m;
    end
    return r[31:0];
  endfunction

  function automatic elg_result_t elgamal_predict(elg_item_t it);
    elg_result_t res;
    longint unsigned p, pm1, xr;
    res.first = '0;
    res.second = '0;
    p = mod_p;
    // A modulus of zero or one answers zero on both fields.
    if (p >= 2) begin
      if (it.cmd == elg_pkg::CMD_ENCRYPT) begin
        res.first = mod_exp(gen_g, it.nonce, mod_p);
        res.second = 32'((longint'(mod_exp(key_y, it.nonce, mod_p)) *
                          (longint'(it.message) % p)) % p);
      end else begin
        // A private key at or above p-1 is folded into range first.
        pm1 = p - 1;
        xr = longint'(key_x) % pm1;
        res.first = 32'((longint'(mod_exp(it.cipher_first, 32'(pm1 - xr), mod_p)) *
                         (longint'(it.cipher_second) % p)) % p);
      end
    end
    return res;
  endfunction

  function automatic elg_item_t make_enc(logic [31:0] msg, logic [31:0] k);
    elg_item_t it;
    it.cmd = elg_pkg::CMD_ENCRYPT;
    it.message = msg;
    it.nonce = k;
    it.cipher_first = $urandom;
    it.cipher_second = $urandom;
    return it;
  endfunction

  function automatic elg_item_t make_dec(logic [31:0] a, logic [31:0] b);
    elg_item_t it;
    it.cmd = elg_pkg::CMD_DECRYPT;
    it.message = $urandom;
    it.nonce = $urandom;
    it.cipher_first = a;
    it.cipher_second = b;
    return it;
  endfunction

  // Appends one item to the pending queue.
  task automatic add_item(elg_item_t it);
    pending_items = {pending_items, it};
  endtask

  // Queues an encrypt and then the decrypt of its predicted ciphertext, so
  // that a round trip with consistent keys returns the message mod p.
  task automatic queue_round_trip(logic [31:0] msg, logic [31:0] k);
    elg_item_t enc;
    elg_result_t ct;
    enc = make_enc(msg, k);
    ct = elgamal_predict(enc);
    add_item(enc);
    add_item(make_dec(ct.first, ct.second));
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch on %s: got %h, want %h", what, got, want);
    errors++;
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Keys are only loaded while nothing is in flight.
  task automatic load_keys(logic [31:0] p, logic [31:0] g, logic [31:0] x,
                           logic [31:0] y);
    write_reg(elg_pkg::REG_MODULUS, p);
    write_reg(elg_pkg::REG_GENERATOR, g);
    write_reg(elg_pkg::REG_PRIVATE_KEY, x);
    write_reg(elg_pkg::REG_PUBLIC_KEY, y);
    mod_p = p;
    gen_g = g;
    key_x = x;
    key_y = y;
  endtask

  task automatic drain;
    @(negedge clk);
    while (pending_items.size() != 0 || in_tvalid || expected_results.size() != 0)
      @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  // Random traffic: mostly round trips with random content, the rest loose
  // items with arbitrary ciphertext or operation.
  task automatic queue_random(int count);
    int n;
    elg_item_t it;
    n = 0;
    while (n < count) begin
      if ($urandom_range(99) < 70) begin
        queue_round_trip($urandom, $urandom);
        n += 2;
      end else begin
        it = $urandom_range(1) ? make_dec($urandom, $urandom)
                               : make_enc($urandom, $urandom);
        add_item(it);
        n++;
      end
    end
  endtask

  // Uses prime p, a random g and keys that agree unless wrong_pub is set.
  task automatic random_phase(logic [31:0] p, int count, bit wrong_pub);
    logic [31:0] g, x, y;
    g = 32'($urandom_range(p - 1, 2));
    x = 32'($urandom_range(p > 4 ? p - 2 : 2, 2));
    y = wrong_pub ? $urandom : mod_exp(g, x, p);
    load_keys(p, g, x, y);
    queue_random(count);
    drain();
  endtask

  // Driver: a new transfer is offered once the previous one has been taken.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready)
        expected_results = {expected_results, elgamal_predict(cur_item)};
      if (!in_tvalid || in_tready) begin
        if (pending_items.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
          cur_item = pending_items.pop_front();
          in_tdata <= {7'b0, cur_item.cipher_second, cur_item.cipher_first,
                       cur_item.nonce, cur_item.message, cur_item.cmd};
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: random back-pressure, and each result transfer is compared
  // against the oldest prediction.
  always @(posedge clk) begin
    elg_result_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result", out_tdata[31:0], 32'h0);
        end else begin
          want = expected_results.pop_front();
          if (out_tdata[31:0] !== want.first)
            report_mismatch("result_first", out_tdata[31:0], want.first);
          if (out_tdata[63:32] !== want.second)
            report_mismatch("result_second", out_tdata[63:32], want.second);
        end
      end
      out_tready <= calm || $urandom_range(99) >= IDLE_PCT;
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Reset keys: p = 3 with a few plain items.
    queue_round_trip(32'd2, 32'd1);
    add_item(make_dec(32'hFFFF_FFFF, 32'hFFFF_FFFF));
    drain();

    // Largest 32-bit prime, unreduced generator and a private key above
    // p-1, so the decrypt exponent gets folded.
    load_keys(32'hFFFF_FFFB, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
              mod_exp(32'd4, 32'hFFFF_FFFF % 32'hFFFF_FFFA, 32'hFFFF_FFFB));
    queue_round_trip(32'd0, 32'd1);
    queue_round_trip(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_round_trip(32'h1234_5678, 32'hFFFF_FFFA);
    queue_round_trip(32'hFFFF_FFFA, 32'hFFFF_FFFB);
    add_item(make_enc(32'hFFFF_FFFB, 32'd0));
    add_item(make_dec(32'd0, 32'hFFFF_FFFF));
    add_item(make_dec(32'hFFFF_FFFF, 32'd0));
    add_item(make_dec(32'hFFFF_FFFB, 32'd5));
    drain();

    // Degenerate moduli answer zero; p = 2 is the smallest real group.
    load_keys(32'd0, 32'd2, 32'd2, 32'd0);
    queue_round_trip(32'hDEAD_BEEF, 32'd7);
    drain();
    load_keys(32'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_round_trip(32'h0000_0001, 32'hFFFF_FFFF);
    drain();
    load_keys(32'd2, 32'd2, 32'd2, 32'd0);
    queue_round_trip(32'd1, 32'd3);
    add_item(make_dec(32'd1, 32'd1));
    drain();

    random_phase(32'd101, 110, 1'b0);
    calm = 1'b1;
    random_phase(32'd65537, 110, 1'b0);
    calm = 1'b0;
    random_phase(32'h7FFF_FFFF, 120, 1'b0);
    random_phase(32'hFFFF_FFFB, 120, 1'b0);
    random_phase(32'd4093, 110, 1'b1);
    random_phase(32'd3, 100, 1'b0);

    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ===== sim.f =====
design/elg_pkg.sv
design/elg_modmul.sv
design/elgamal_encrypt_decrypt.sv
bench/tb_elgamal_encrypt_decrypt.sv
